>>> sv/srfc_pkg.sv
// Package with the constants, codes and control types of the schedule feasibility checker.
`timescale 1ns / 1ps

package srfc_pkg;

  localparam int MAX_JOBS      = 64;
  localparam int NUM_RESOURCES = 4;
  localparam int HORIZON       = 1024;

  localparam int JOB_AW    = $clog2(MAX_JOBS);
  localparam int CAP_DEPTH = NUM_RESOURCES * HORIZON;
  localparam int CAP_AW    = $clog2(CAP_DEPTH);

  localparam int START_W = 10;
  localparam int LEN_W   = 11;
  localparam int SLOT_W  = 10;
  localparam int AMT_W   = 16;
  localparam int JOB_W   = START_W + LEN_W;
  localparam int EARLY_W = LEN_W + 1;
  localparam int T_W     = SLOT_W + 1;

  localparam logic [2:0] REQ_CLEAR = 3'd0;
  localparam logic [2:0] REQ_CAP   = 3'd1;
  localparam logic [2:0] REQ_JOB   = 3'd2;
  localparam logic [2:0] REQ_EDGE  = 3'd3;
  localparam logic [2:0] REQ_DEM   = 3'd4;
  localparam logic [2:0] REQ_END   = 3'd5;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_PREC    = 3'd1;
  localparam logic [2:0] ERR_CAP     = 3'd2;
  localparam logic [2:0] ERR_HORIZON = 3'd3;
  localparam logic [2:0] ERR_EMPTY   = 3'd4;

  typedef struct packed {
    logic load;
    logic clear;
    logic cap_load;
    logic job_wr;
    logic jrd_pred;
    logic earliest;
    logic prec_chk;
    logic dem_rd;
    logic dem_upd;
    logic end_chk;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       out_busy;
  } status_t;

endpackage

>>> sv/srfc_if.sv
// Handshake interfaces for the request and result channels.
`timescale 1ns / 1ps

interface srfc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [5:0]  job_index;
  logic [5:0]  pred_index;
  logic [1:0]  resource_index;
  logic [9:0]  time_slot;
  logic [9:0]  start_time;
  logic [10:0] job_length;
  logic [15:0] amount;

  modport source (output valid, req_type, job_index, pred_index, resource_index, time_slot,
                  start_time, job_length, amount, input ready);
  modport sink (input valid, req_type, job_index, pred_index, resource_index, time_slot,
                start_time, job_length, amount, output ready);
endinterface

interface srfc_out_if;
  logic       valid;
  logic       ready;
  logic       still_valid;
  logic [2:0] error_code;
  logic       verdict_ready;

  modport source (output valid, still_valid, error_code, verdict_ready, input ready);
  modport sink (input valid, still_valid, error_code, verdict_ready, output ready);
endinterface

>>> sv/srfc_ram.sv
// Generic simple dual-port RAM with a registered read.
`timescale 1ns / 1ps

module srfc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/srfc_ctrl.sv
// Controller state machine that sequences each transaction through the datapath.
`timescale 1ns / 1ps

module srfc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  srfc_pkg::status_t status_i,
  output srfc_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISP,
    ST_E_WAIT,
    ST_E_CMP,
    ST_D_WAIT,
    ST_D_UPD,
    ST_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_DISP;
        end
      end
      ST_DISP: begin
        state_d = ST_DONE;
        unique case (status_i.req)
          srfc_pkg::REQ_CLEAR: cmd_o.clear = 1'b1;
          srfc_pkg::REQ_CAP:   cmd_o.cap_load = 1'b1;
          srfc_pkg::REQ_JOB:   cmd_o.job_wr = 1'b1;
          srfc_pkg::REQ_EDGE: begin
            cmd_o.jrd_pred = 1'b1;
            state_d        = ST_E_WAIT;
          end
          srfc_pkg::REQ_DEM:   state_d = ST_D_WAIT;
          srfc_pkg::REQ_END:   cmd_o.end_chk = 1'b1;
          default: ;
        endcase
      end
      ST_E_WAIT: begin
        cmd_o.earliest = 1'b1;
        state_d        = ST_E_CMP;
      end
      ST_E_CMP: begin
        cmd_o.prec_chk = 1'b1;
        state_d        = ST_DONE;
      end
      ST_D_WAIT: begin
        cmd_o.dem_rd = 1'b1;
        state_d      = ST_D_UPD;
      end
      ST_D_UPD: begin
        cmd_o.dem_upd = 1'b1;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

>>> sv/srfc_dp.sv
// Datapath with the item registers, job and capacity memories, verdict and result register.
`timescale 1ns / 1ps

module srfc_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  srfc_pkg::cmd_t     cmd_i,
  output srfc_pkg::status_t  status_o,
  input  logic [2:0]         req_type_i,
  input  logic [5:0]         job_index_i,
  input  logic [5:0]         pred_index_i,
  input  logic [1:0]         resource_index_i,
  input  logic [9:0]         time_slot_i,
  input  logic [9:0]         start_time_i,
  input  logic [10:0]        job_length_i,
  input  logic [15:0]        amount_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               still_valid_o,
  output logic [2:0]         error_code_o,
  output logic               verdict_ready_o
);

  logic [2:0]                     req_q;
  logic [5:0]                     job_q;
  logic [5:0]                     pred_q;
  logic [1:0]                     res_q;
  logic [srfc_pkg::SLOT_W-1:0]    slot_q;
  logic [srfc_pkg::START_W-1:0]   start_q;
  logic [srfc_pkg::LEN_W-1:0]     len_q;
  logic [srfc_pkg::AMT_W-1:0]     amt_q;

  logic [2:0]                     first_error_q, first_error_d;
  logic                           any_job_q, any_job_d;
  logic [srfc_pkg::EARLY_W-1:0]   earliest_q;
  logic [srfc_pkg::CAP_AW-1:0]    dem_addr_q;
  logic                           dem_act_q;
  logic                           dem_hz_q;

  logic                           out_valid_q;
  logic                           out_still_q;
  logic [2:0]                     out_err_q;
  logic                           out_verdict_q;

  logic                           job_ok;
  logic                           pred_ok;
  logic                           res_ok;
  logic                           flag;
  logic [2:0]                     flag_code;

  logic                           job_we;
  logic [srfc_pkg::JOB_AW-1:0]    job_raddr;
  logic [srfc_pkg::JOB_W-1:0]     job_rdata;
  logic [srfc_pkg::START_W-1:0]   rd_start;
  logic [srfc_pkg::LEN_W-1:0]     rd_len;

  logic [srfc_pkg::T_W-1:0]       dem_t;
  logic [srfc_pkg::CAP_AW-1:0]    dem_addr_d;
  logic                           cap_we;
  logic [srfc_pkg::CAP_AW-1:0]    cap_waddr;
  logic [srfc_pkg::AMT_W-1:0]     cap_wdata;
  logic [srfc_pkg::AMT_W-1:0]     cap_rdata;

  assign job_ok  = int'(job_q) < srfc_pkg::MAX_JOBS;
  assign pred_ok = int'(pred_q) < srfc_pkg::MAX_JOBS;
  assign res_ok  = int'(res_q) < srfc_pkg::NUM_RESOURCES;

  assign rd_start = job_rdata[srfc_pkg::JOB_W-1:srfc_pkg::LEN_W];
  assign rd_len   = job_rdata[srfc_pkg::LEN_W-1:0];

  assign job_we    = cmd_i.job_wr && job_ok;
  assign job_raddr = cmd_i.jrd_pred ? srfc_pkg::JOB_AW'(pred_q) : srfc_pkg::JOB_AW'(job_q);

  assign dem_t      = srfc_pkg::T_W'(rd_start) + srfc_pkg::T_W'(slot_q);
  assign dem_addr_d = srfc_pkg::CAP_AW'(res_q) * srfc_pkg::CAP_AW'(srfc_pkg::HORIZON)
                    + srfc_pkg::CAP_AW'(dem_t);

  srfc_ram #(
    .WIDTH(srfc_pkg::JOB_W),
    .DEPTH(srfc_pkg::MAX_JOBS)
  ) u_job_ram (
    .clk_i   (clk_i),
    .we_i    (job_we),
    .waddr_i (srfc_pkg::JOB_AW'(job_q)),
    .wdata_i ({start_q, len_q}),
    .raddr_i (job_raddr),
    .rdata_o (job_rdata)
  );

  srfc_ram #(
    .WIDTH(srfc_pkg::AMT_W),
    .DEPTH(srfc_pkg::CAP_DEPTH)
  ) u_cap_ram (
    .clk_i   (clk_i),
    .we_i    (cap_we),
    .waddr_i (cap_waddr),
    .wdata_i (cap_wdata),
    .raddr_i (dem_addr_d),
    .rdata_o (cap_rdata)
  );

  always_comb begin
    cap_we    = 1'b0;
    cap_waddr = dem_addr_q;
    cap_wdata = amt_q;
    flag      = 1'b0;
    flag_code = srfc_pkg::ERR_NONE;
    any_job_d = any_job_q;
    if (cmd_i.cap_load && res_ok) begin
      if (int'(slot_q) >= srfc_pkg::HORIZON) begin
        flag      = 1'b1;
        flag_code = srfc_pkg::ERR_HORIZON;
      end else begin
        cap_we    = 1'b1;
        cap_waddr = srfc_pkg::CAP_AW'(res_q) * srfc_pkg::CAP_AW'(srfc_pkg::HORIZON)
                  + srfc_pkg::CAP_AW'(slot_q);
      end
    end
    if (job_we) begin
      any_job_d = 1'b1;
    end
    if (cmd_i.prec_chk && job_ok && pred_ok &&
        (srfc_pkg::EARLY_W'(rd_start) < earliest_q)) begin
      flag      = 1'b1;
      flag_code = srfc_pkg::ERR_PREC;
    end
    if (cmd_i.dem_upd && dem_act_q) begin
      if (dem_hz_q) begin
        flag      = 1'b1;
        flag_code = srfc_pkg::ERR_HORIZON;
      end else if (amt_q > cap_rdata) begin
        cap_we    = 1'b1;
        cap_wdata = '0;
        flag      = 1'b1;
        flag_code = srfc_pkg::ERR_CAP;
      end else begin
        cap_we    = 1'b1;
        cap_wdata = cap_rdata - amt_q;
      end
    end
    if (cmd_i.end_chk && !any_job_q) begin
      flag      = 1'b1;
      flag_code = srfc_pkg::ERR_EMPTY;
    end
    first_error_d = first_error_q;
    if (flag && (first_error_q == srfc_pkg::ERR_NONE)) begin
      first_error_d = flag_code;
    end
    if (cmd_i.clear) begin
      first_error_d = srfc_pkg::ERR_NONE;
      any_job_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= req_type_i;
      job_q   <= job_index_i;
      pred_q  <= pred_index_i;
      res_q   <= resource_index_i;
      slot_q  <= time_slot_i;
      start_q <= start_time_i;
      len_q   <= job_length_i;
      amt_q   <= amount_i;
    end
    if (cmd_i.earliest) begin
      earliest_q <= srfc_pkg::EARLY_W'(rd_start) + srfc_pkg::EARLY_W'(rd_len);
    end
    if (cmd_i.dem_rd) begin
      dem_addr_q <= dem_addr_d;
      dem_act_q  <= job_ok && res_ok && (srfc_pkg::LEN_W'(slot_q) < rd_len);
      dem_hz_q   <= int'(dem_t) >= srfc_pkg::HORIZON;
    end
    if (cmd_i.out_load) begin
      out_still_q   <= (first_error_q == srfc_pkg::ERR_NONE);
      out_err_q     <= first_error_q;
      out_verdict_q <= (req_q == srfc_pkg::REQ_END);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_error_q <= srfc_pkg::ERR_NONE;
      any_job_q     <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      first_error_q <= first_error_d;
      any_job_q     <= any_job_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.req      = req_q;
  assign status_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign still_valid_o   = out_still_q;
  assign error_code_o    = out_err_q;
  assign verdict_ready_o = out_verdict_q;

endmodule

>>> sv/schedule_resource_feasibility_check_unit.sv
// Top level of the resource-constrained schedule feasibility checker.
// The request channel carries one transaction per item: clear, capacity load, job record,
// precedence edge, demand or end check. The result channel returns exactly one transaction
// per request with still_valid, the sticky first error_code and verdict_ready, which is set
// only on the result of an end check.
// Items are processed one at a time. Clear, capacity, job, end check and unused codes go
// from dispatch straight to the done state; precedence edges and demands pass through a
// wait and a compare or update state first, set by the sequential reads through the single
// read port of the job memory and the read-modify-write of the capacity memory. A result is
// loaded into the output register in the done state, once that register is free.
// Results sit in an output register, so the next request is accepted while an earlier result
// still waits. If the receiver stalls with a result pending, the following item finishes its
// work and then holds until that register is free.
// Reset clears the verdict, the job-seen flag, the controller and the output valid. The
// capacity and job memories are not cleared and must be written before they are read.
`timescale 1ns / 1ps

module schedule_resource_feasibility_check_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  srfc_in_if.sink       in_i,
  srfc_out_if.source    out_o
);

  srfc_pkg::cmd_t    cmd;
  srfc_pkg::status_t status;

  srfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  srfc_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .req_type_i       (in_i.req_type),
    .job_index_i      (in_i.job_index),
    .pred_index_i     (in_i.pred_index),
    .resource_index_i (in_i.resource_index),
    .time_slot_i      (in_i.time_slot),
    .start_time_i     (in_i.start_time),
    .job_length_i     (in_i.job_length),
    .amount_i         (in_i.amount),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .still_valid_o    (out_o.still_valid),
    .error_code_o     (out_o.error_code),
    .verdict_ready_o  (out_o.verdict_ready)
  );

endmodule

>>> tb/schedule_resource_feasibility_check_unit_tb.sv
// Self-checking testbench of the schedule feasibility checker with a built-in verdict predictor.
`timescale 1ns / 1ps

module schedule_resource_feasibility_check_unit_tb;

  localparam logic [2:0] REQ_SPARE_LO = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;
  localparam int LONG_HOLD     = 300;
  localparam int STUCK_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_ITEMS  = 1050;

  typedef struct packed {
    logic [2:0]  req;
    logic [5:0]  job;
    logic [5:0]  pred;
    logic [1:0]  res;
    logic [9:0]  slot;
    logic [9:0]  start;
    logic [10:0] len;
    logic [15:0] amt;
  } request_t;

  typedef struct packed {
    logic       still_valid;
    logic [2:0] error_code;
    logic       verdict_ready;
  } verdict_t;

  logic clk;
  logic rst_n;

  srfc_in_if  req_if ();
  srfc_out_if rsp_if ();

  schedule_resource_feasibility_check_unit u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  logic [srfc_pkg::AMT_W-1:0]   cap_left   [srfc_pkg::CAP_DEPTH];
  bit                           cap_loaded [srfc_pkg::CAP_DEPTH];
  logic [srfc_pkg::START_W-1:0] job_begin  [srfc_pkg::MAX_JOBS];
  logic [srfc_pkg::LEN_W-1:0]   job_len    [srfc_pkg::MAX_JOBS];
  bit                           job_loaded [srfc_pkg::MAX_JOBS];
  logic [2:0]                   first_violation;
  bit                           any_job;

  verdict_t pending_verdicts[$];
  int       sent_items;
  int       checked_results;
  int       mismatches;
  int       stuck_cycles;
  int       end_by_code[5];
  bit       tx_idle_en;
  bit       rx_idle_en;
  bit       long_hold_req;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int idle_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void flag_violation(input logic [2:0] code);
    if (first_violation == srfc_pkg::ERR_NONE) first_violation = code;
  endfunction

  function automatic verdict_t predict_verdict(input request_t r);
    logic [srfc_pkg::EARLY_W-1:0] earliest;
    logic [srfc_pkg::T_W-1:0]     t;
    int                           idx;
    verdict_t                     v;
    v.verdict_ready = 1'b0;
    case (r.req)
      srfc_pkg::REQ_CLEAR: begin
        first_violation = srfc_pkg::ERR_NONE;
        any_job = 1'b0;
      end
      srfc_pkg::REQ_CAP: begin
        if (r.slot >= srfc_pkg::HORIZON) begin
          flag_violation(srfc_pkg::ERR_HORIZON);
        end else begin
          idx = r.res * srfc_pkg::HORIZON + r.slot;
          cap_left[idx] = r.amt;
          cap_loaded[idx] = 1'b1;
        end
      end
      srfc_pkg::REQ_JOB: begin
        job_begin[r.job] = r.start;
        job_len[r.job] = r.len;
        job_loaded[r.job] = 1'b1;
        any_job = 1'b1;
      end
      srfc_pkg::REQ_EDGE: begin
        earliest = job_begin[r.pred] + job_len[r.pred];
        if (job_begin[r.job] < earliest) flag_violation(srfc_pkg::ERR_PREC);
      end
      srfc_pkg::REQ_DEM: begin
        if (r.slot < job_len[r.job]) begin
          t = job_begin[r.job] + r.slot;
          if (t >= srfc_pkg::HORIZON) begin
            flag_violation(srfc_pkg::ERR_HORIZON);
          end else begin
            idx = r.res * srfc_pkg::HORIZON + t;
            if (r.amt > cap_left[idx]) begin
              cap_left[idx] = '0;
              flag_violation(srfc_pkg::ERR_CAP);
            end else begin
              cap_left[idx] = cap_left[idx] - r.amt;
            end
          end
        end
      end
      srfc_pkg::REQ_END: begin
        if (!any_job) flag_violation(srfc_pkg::ERR_EMPTY);
        v.verdict_ready = 1'b1;
      end
      default: begin
      end
    endcase
    v.still_valid = (first_violation == srfc_pkg::ERR_NONE);
    v.error_code = first_violation;
    return v;
  endfunction

  function automatic request_t make_request(input logic [2:0] kind);
    request_t r;
    r.req   = kind;
    r.job   = 6'($urandom);
    r.pred  = 6'($urandom);
    r.res   = 2'($urandom);
    r.slot  = 10'($urandom);
    r.start = 10'($urandom);
    r.len   = 11'($urandom);
    r.amt   = 16'($urandom);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch on %s at result %0d: got %0d, expected %0d",
               what, checked_results, got, want);
  endtask

  task automatic send_request(input request_t r);
    int gap;
    gap = tx_idle_en ? idle_length() : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid          <= 1'b1;
    req_if.req_type       <= r.req;
    req_if.job_index      <= r.job;
    req_if.pred_index     <= r.pred;
    req_if.resource_index <= r.res;
    req_if.time_slot      <= r.slot;
    req_if.start_time     <= r.start;
    req_if.job_length     <= r.len;
    req_if.amount         <= r.amt;
    do @(posedge clk); while (!req_if.ready);
    pending_verdicts.push_back(predict_verdict(r));
    sent_items++;
  endtask

  task automatic ensure_job(input logic [5:0] j);
    request_t r;
    if (!job_loaded[j]) begin
      r = make_request(srfc_pkg::REQ_JOB);
      r.job = j;
      send_request(r);
    end
  endtask

  // Edges and demands only read job and capacity entries that hold a value.
  task automatic send_checked(input request_t r);
    logic [srfc_pkg::T_W-1:0] t;
    request_t                 fill;
    if (r.req == srfc_pkg::REQ_EDGE) begin
      ensure_job(r.pred);
      ensure_job(r.job);
    end else if (r.req == srfc_pkg::REQ_DEM) begin
      ensure_job(r.job);
      t = job_begin[r.job] + r.slot;
      if (r.slot < job_len[r.job] && t < srfc_pkg::HORIZON &&
          !cap_loaded[r.res * srfc_pkg::HORIZON + t]) begin
        fill = make_request(srfc_pkg::REQ_CAP);
        fill.res = r.res;
        fill.slot = 10'(t);
        send_request(fill);
      end
    end
    send_request(r);
  endtask

  task automatic send_simple(input logic [2:0] kind);
    send_request(make_request(kind));
  endtask

  task automatic send_cap(input logic [1:0] res, input logic [9:0] slot, input logic [15:0] amt);
    request_t r;
    r = make_request(srfc_pkg::REQ_CAP);
    r.res = res;
    r.slot = slot;
    r.amt = amt;
    send_request(r);
  endtask

  task automatic send_job(input logic [5:0] j, input logic [9:0] st, input logic [10:0] len);
    request_t r;
    r = make_request(srfc_pkg::REQ_JOB);
    r.job = j;
    r.start = st;
    r.len = len;
    send_request(r);
  endtask

  task automatic send_edge(input logic [5:0] j, input logic [5:0] p);
    request_t r;
    r = make_request(srfc_pkg::REQ_EDGE);
    r.job = j;
    r.pred = p;
    send_checked(r);
  endtask

  task automatic send_demand(input logic [5:0] j, input logic [1:0] res,
                             input logic [9:0] slot, input logic [15:0] amt);
    request_t r;
    r = make_request(srfc_pkg::REQ_DEM);
    r.job = j;
    r.res = res;
    r.slot = slot;
    r.amt = amt;
    send_checked(r);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_schedule();
    send_simple(srfc_pkg::REQ_END);
    send_simple(REQ_SPARE_LO);
    send_simple(REQ_SPARE_HI);
    send_simple(srfc_pkg::REQ_CLEAR);
  endtask

  task automatic test_directed_cases();
    send_cap(2'd0, 10'd0, 16'hFFFF);
    send_job(6'd0, 10'd0, 11'd1);
    send_job(6'd1, 10'd1, 11'd1024);
    send_edge(6'd1, 6'd0);
    send_demand(6'd0, 2'd0, 10'd0, 16'hFFFF);
    send_demand(6'd0, 2'd0, 10'd1, 16'hFFFF);
    send_job(6'd2, 10'd0, 11'd0);
    send_demand(6'd2, 2'd1, 10'd0, 16'd5);
    send_simple(srfc_pkg::REQ_END);

    send_simple(srfc_pkg::REQ_CLEAR);
    send_job(6'd5, 10'd10, 11'd5);
    send_job(6'd6, 10'd14, 11'd3);
    send_edge(6'd6, 6'd5);
    send_demand(6'd6, 2'd2, 10'd0, 16'hFFFF);
    send_simple(srfc_pkg::REQ_END);

    send_simple(srfc_pkg::REQ_CLEAR);
    send_job(6'd7, 10'd100, 11'd10);
    send_cap(2'd2, 10'd105, 16'd10);
    send_demand(6'd7, 2'd2, 10'd5, 16'd11);
    send_demand(6'd7, 2'd2, 10'd5, 16'd0);
    send_simple(srfc_pkg::REQ_END);

    send_simple(srfc_pkg::REQ_CLEAR);
    send_cap(2'd3, 10'd1023, 16'd0);
    send_job(6'd63, 10'd1023, 11'd2047);
    send_demand(6'd63, 2'd3, 10'd0, 16'd0);
    send_demand(6'd63, 2'd3, 10'd1, 16'd1);
    send_simple(srfc_pkg::REQ_END);
    send_simple(srfc_pkg::REQ_CLEAR);
  endtask

  task automatic test_back_pressure();
    bit saved_tx;
    saved_tx = tx_idle_en;
    wait_drained();
    tx_idle_en = 1'b0;
    long_hold_req <= 1'b1;
    repeat (12) send_checked(make_request(3'($urandom_range(0, 5))));
    wait_drained();
    tx_idle_en = saved_tx;
  endtask

  function automatic logic [10:0] pick_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 11'($urandom_range(1, 8));
    if (roll < 80) return '0;
    if (roll < 92) return 11'($urandom_range(9, 200));
    if (roll < 97) return 11'($urandom_range(201, 1024));
    return 11'($urandom_range(1025, 2047));
  endfunction

  function automatic logic [15:0] pick_capacity();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 20) return 16'hFFFF;
    return 16'($urandom_range(1, 1000));
  endfunction

  function automatic logic [15:0] pick_demand();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 15) return 16'hFFFF;
    return 16'($urandom_range(0, 600));
  endfunction

  task automatic run_schedule();
    int          n;
    logic [5:0]  jobs   [6];
    logic [9:0]  starts [6];
    logic [10:0] lens   [6];
    logic [9:0]  cursor;
    logic [9:0]  slot;
    if ($urandom_range(0, 9) != 0) send_simple(srfc_pkg::REQ_CLEAR);
    n = $urandom_range(2, 6);
    cursor = 10'(($urandom_range(0, 9) == 0) ? $urandom_range(1000, 1023)
                                              : $urandom_range(0, 900));
    for (int i = 0; i < n; i++) begin
      jobs[i] = 6'($urandom_range(0, 63));
      lens[i] = pick_length();
      starts[i] = (i > 0 && $urandom_range(0, 7) == 0) ? cursor - 10'd1 : cursor;
      for (int k = 0; k < 3 && k < lens[i]; k++) begin
        if (starts[i] + k < srfc_pkg::HORIZON)
          send_cap(2'($urandom), 10'(starts[i] + k), pick_capacity());
      end
      send_job(jobs[i], starts[i], lens[i]);
      cursor = 10'(starts[i] + lens[i]);
    end
    for (int i = 1; i < n; i++) send_edge(jobs[i], jobs[i - 1]);
    send_edge(jobs[$urandom_range(0, n - 1)], jobs[$urandom_range(0, n - 1)]);
    for (int i = 0; i < n; i++) begin
      repeat ($urandom_range(1, 3)) begin
        slot = 10'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                               : $urandom_range(0, 4));
        send_demand(jobs[i], 2'($urandom), slot, pick_demand());
      end
    end
    send_simple(srfc_pkg::REQ_END);
  endtask

  task automatic test_random_schedules();
    int target;
    target = sent_items + RANDOM_ITEMS;
    while (sent_items < target) begin
      tx_idle_en = ($urandom_range(0, 4) != 0);
      rx_idle_en <= ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(5, 20)) send_checked(make_request(3'($urandom)));
      end else begin
        run_schedule();
      end
    end
  endtask

  // Compare every result transaction with the oldest prediction.
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result without request", 1, 0);
      end else begin
        want = pending_verdicts.pop_front();
        if (rsp_if.still_valid !== want.still_valid)
          report_mismatch("still_valid", int'(rsp_if.still_valid), int'(want.still_valid));
        if (rsp_if.error_code !== want.error_code)
          report_mismatch("error_code", int'(rsp_if.error_code), int'(want.error_code));
        if (rsp_if.verdict_ready !== want.verdict_ready)
          report_mismatch("verdict_ready", int'(rsp_if.verdict_ready),
                          int'(want.verdict_ready));
        if (want.verdict_ready && want.error_code <= srfc_pkg::ERR_EMPTY)
          end_by_code[want.error_code]++;
      end
      checked_results++;
    end
  end

  initial begin
    int stall;
    rsp_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        rsp_if.ready <= 1'b0;
        long_hold_req <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        rsp_if.ready <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        stall = idle_length();
        if (stall == 0) stall = 1;
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("[schedule_resource_feasibility_check_unit] ERROR");
      $finish;
    end
  end

  initial begin
    rst_n                 = 1'b0;
    req_if.valid          = 1'b0;
    req_if.req_type       = srfc_pkg::REQ_CLEAR;
    req_if.job_index      = '0;
    req_if.pred_index     = '0;
    req_if.resource_index = '0;
    req_if.time_slot      = '0;
    req_if.start_time     = '0;
    req_if.job_length     = '0;
    req_if.amount         = '0;
    first_violation       = srfc_pkg::ERR_NONE;
    any_job               = 1'b0;
    tx_idle_en            = 1'b1;
    rx_idle_en            = 1'b1;
    long_hold_req         = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_schedule();
    test_directed_cases();
    test_back_pressure();
    test_random_schedules();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d requests and checked %0d results, including a long output stall.",
             sent_items, checked_results);
    $display("End-check verdicts: feasible %0d, precedence %0d, capacity %0d, %s %0d, %s %0d.",
             end_by_code[0], end_by_code[1], end_by_code[2], "horizon", end_by_code[3],
             "empty", end_by_code[4]);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("[schedule_resource_feasibility_check_unit] OK");
    end else begin
      $display("[schedule_resource_feasibility_check_unit] ERROR");
    end
    $finish;
  end

endmodule
